// ----- src/integer_to_ascii_in_base_top_defines.svh -----
// Assertion macros shared by the integer-to-text block.
// Needs a clock named clk and an active-high reset named rst in the including scope.
`ifndef INTEGER_TO_ASCII_IN_BASE_TOP_DEFINES_SVH
`define INTEGER_TO_ASCII_IN_BASE_TOP_DEFINES_SVH

// Condition that must hold at every clock edge outside reset.
`define ITOAB_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Consequence that must hold in the same cycle as the antecedent.
`define ITOAB_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequence that must hold in the cycle after the antecedent.
`define ITOAB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/itoab_pkg.sv -----
// Shared types, constants and the digit character table of the integer-to-text block.
// No dependencies.
package itoab_pkg;

  localparam int unsigned NUMBER_W = 32;
  localparam int unsigned RADIX_W  = 5;
  localparam int unsigned DIGIT_W  = 4;
  localparam int unsigned CHAR_W   = 8;

  localparam logic [RADIX_W-1:0] RADIX_MIN   = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX   = 5'd16;
  localparam logic [RADIX_W-1:0] RADIX_DEC   = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_RESET = 5'd10;

  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

  localparam logic [CHAR_W-1:0] DIGIT_CHARS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_STORE,
    ST_SIGN,
    ST_READ,
    ST_SHOW
  } itoab_state_t;

  typedef struct packed {
    logic load;
    logic restart;
    logic step;
  } div_ctl_t;

  typedef struct packed {
    logic [DIGIT_W-1:0] digit;
    logic               quot_nz;
  } div_stat_t;

  function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
    return DIGIT_CHARS[d];
  endfunction

endpackage

// ----- src/itoab_if.sv -----
// Handshake channels of the integer-to-text block: the number input and the character output.
// Depends on itoab_pkg for the field widths.
interface itoab_num_if import itoab_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [NUMBER_W-1:0] number;

  modport source (output valid, output number, input ready);
  modport sink (input valid, input number, output ready);
endinterface

interface itoab_char_if import itoab_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

// ----- src/itoab_serial_div.sv -----
// Bit-serial restoring divider by a small radix: one dividend bit per cycle.
// Depends on itoab_pkg for the control and status structs.
module itoab_serial_div import itoab_pkg::*; #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic                  clk,
  input  div_ctl_t              ctl,
  input  logic [RADIX_W-1:0]    base,
  input  logic [VALUE_BITS-1:0] load_value,
  output div_stat_t             stat
);

  logic [VALUE_BITS-1:0] mag;
  logic [DIGIT_W-1:0]    rem;
  logic                  qnz;
  logic [RADIX_W-1:0]    trial;
  logic [RADIX_W-1:0]    diff;
  logic                  ge;

  // The partial remainder stays below the radix, so it fits in one digit.
  always_comb begin
    trial = {rem, mag[VALUE_BITS-1]};
    ge    = (trial >= base);
    diff  = trial - base;
  end

  // The quotient bits shift in behind the dividend, so after a full pass the
  // register holds the quotient ready for the next digit.
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mag <= load_value;
      rem <= '0;
      qnz <= 1'b0;
    end else if (ctl.restart) begin
      rem <= '0;
      qnz <= 1'b0;
    end else if (ctl.step) begin
      mag <= {mag[VALUE_BITS-2:0], ge};
      rem <= ge ? diff[DIGIT_W-1:0] : trial[DIGIT_W-1:0];
      qnz <= qnz | ge;
    end
  end

  assign stat.digit   = rem;
  assign stat.quot_nz = qnz;

endmodule

// ----- src/itoab_digit_ram.sv -----
// Digit store: one write port and one read port with registered read data.
// Depends on itoab_pkg for the digit width.
module itoab_digit_ram import itoab_pkg::*; #(
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DIGIT_W-1:0]       wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DIGIT_W-1:0]       rdata
);

  logic [DIGIT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- src/integer_to_ascii_in_base_top.sv -----
// Top level of the integer-to-text block: sequencer, radix register and output register.
// Depends on itoab_pkg, itoab_if, itoab_serial_div, itoab_digit_ram and the defines header.
//
// Converts one two's complement integer per input beat on number_ch into its text in the
// base held by the radix register, one ASCII character per beat on char_ch, most
// significant digit first, with last_char set on the final character. In base ten a
// negative number is preceded by '-'; in other bases the bit pattern prints as unsigned.
// The radix register is written through cfg_we and cfg_wdata; values below two act as two
// and values above sixteen act as sixteen. Reset sets the radix to ten and empties the block.
// Each digit comes out of a bit-serial divider that makes one pass over the magnitude
// and then stores the digit. Each digit character then leaves through the digit store's
// registered read port, in a read state followed by a show state; a minus sign is
// loaded straight into the output register. number_ch.ready is high only between items.
// A stall on char_ch holds the current character in the output register and pauses the
// sequencer before it loads the next character; nothing is lost.
`include "integer_to_ascii_in_base_top_defines.svh"

module integer_to_ascii_in_base_top import itoab_pkg::*; #(
  parameter int unsigned VALUE_BITS = 32
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [RADIX_W-1:0] cfg_wdata,
  itoab_num_if.sink          number_ch,
  itoab_char_if.source       char_ch
);

  localparam int unsigned CNT_W  = $clog2(VALUE_BITS + 1);
  localparam int unsigned ADDR_W = $clog2(VALUE_BITS);
  localparam int unsigned BIT_W  = $clog2(VALUE_BITS);

  itoab_state_t state, state_next;

  logic [RADIX_W-1:0]    radix;
  logic [RADIX_W-1:0]    radix_eff;
  logic [RADIX_W-1:0]    base;
  logic                  sign_pending;
  logic [CNT_W-1:0]      digit_cnt;
  logic [BIT_W-1:0]      bit_cnt;
  logic                  char_v;
  logic [CHAR_W-1:0]     char_code;
  logic                  char_last;

  logic [VALUE_BITS-1:0] value_in;
  logic [VALUE_BITS-1:0] value_neg;
  logic                  is_neg;
  logic                  in_acc;
  logic                  out_free;
  logic                  load_sign;
  logic                  load_digit;
  logic                  pass_end;
  logic                  more_digits;

  div_ctl_t              div_ctl;
  div_stat_t             div_stat;
  logic                  ram_we;
  logic                  ram_re;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [ADDR_W-1:0]     ram_raddr;
  logic [CNT_W-1:0]      cnt_dec;
  logic [DIGIT_W-1:0]    ram_rdata;

  // The input field is narrowed or sign-extended to the working width.
  generate
    if (VALUE_BITS <= NUMBER_W) begin : g_narrow
      assign value_in = number_ch.number[VALUE_BITS-1:0];
    end else begin : g_wide
      assign value_in = {{(VALUE_BITS - NUMBER_W){number_ch.number[NUMBER_W-1]}},
                         number_ch.number};
    end
  endgenerate

  always_comb begin
    if (radix < RADIX_MIN) begin
      radix_eff = RADIX_MIN;
    end else if (radix > RADIX_MAX) begin
      radix_eff = RADIX_MAX;
    end else begin
      radix_eff = radix;
    end
  end

  // Only base ten treats the top bit as a sign; the most negative value negates to itself,
  // which read as unsigned is exactly its magnitude.
  assign is_neg    = (radix_eff == RADIX_DEC) && value_in[VALUE_BITS-1];
  assign value_neg = ~value_in + {{(VALUE_BITS - 1){1'b0}}, 1'b1};

  assign number_ch.ready = (state == ST_IDLE);
  assign in_acc          = number_ch.valid && number_ch.ready;
  assign out_free        = !char_v || char_ch.ready;
  assign pass_end        = (bit_cnt == BIT_W'(VALUE_BITS - 1));
  assign more_digits     = div_stat.quot_nz && (digit_cnt < CNT_W'(VALUE_BITS - 1));
  assign cnt_dec         = digit_cnt - {{(CNT_W - 1){1'b0}}, 1'b1};

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = ST_DIV;
        end
      end
      ST_DIV: begin
        if (pass_end) begin
          state_next = ST_STORE;
        end
      end
      ST_STORE: begin
        if (more_digits) begin
          state_next = ST_DIV;
        end else if (sign_pending) begin
          state_next = ST_SIGN;
        end else begin
          state_next = ST_READ;
        end
      end
      ST_SIGN: begin
        if (out_free) begin
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        state_next = ST_SHOW;
      end
      ST_SHOW: begin
        if (out_free) begin
          state_next = (digit_cnt == '0) ? ST_IDLE : ST_READ;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    div_ctl.load    = in_acc;
    div_ctl.restart = (state == ST_STORE);
    div_ctl.step    = (state == ST_DIV);
    ram_we          = (state == ST_STORE);
    ram_waddr       = digit_cnt[ADDR_W-1:0];
    ram_re          = (state == ST_READ);
    ram_raddr       = cnt_dec[ADDR_W-1:0];
    load_sign       = (state == ST_SIGN) && out_free;
    load_digit      = (state == ST_SHOW) && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      radix <= RADIX_RESET;
    end else if (cfg_we) begin
      radix <= cfg_wdata;
    end
  end

  // Per-item base, sign flag and counters. The digit count doubles as the read pointer while emitting.
  always_ff @(posedge clk) begin
    if (rst) begin
      base         <= RADIX_DEC;
      sign_pending <= 1'b0;
      digit_cnt    <= '0;
      bit_cnt      <= '0;
    end else begin
      if (in_acc) begin
        base         <= radix_eff;
        sign_pending <= is_neg;
        digit_cnt    <= '0;
        bit_cnt      <= '0;
      end
      if (state == ST_DIV) begin
        bit_cnt <= pass_end ? '0 : bit_cnt + {{(BIT_W - 1){1'b0}}, 1'b1};
      end
      if (state == ST_STORE) begin
        digit_cnt <= digit_cnt + {{(CNT_W - 1){1'b0}}, 1'b1};
      end
      if (load_sign) begin
        sign_pending <= 1'b0;
      end
      if (state == ST_READ) begin
        digit_cnt <= cnt_dec;
      end
    end
  end

  // Output register: it holds its beat through a stall and reloads only once it is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      char_v <= 1'b0;
    end else if (load_sign || load_digit) begin
      char_v <= 1'b1;
    end else if (char_ch.ready) begin
      char_v <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_sign) begin
      char_code <= CHAR_MINUS;
      char_last <= 1'b0;
    end else if (load_digit) begin
      char_code <= digit_char(ram_rdata);
      char_last <= (digit_cnt == '0);
    end
  end

  assign char_ch.valid     = char_v;
  assign char_ch.char_code = char_code;
  assign char_ch.last_char = char_last;

  itoab_serial_div #(
    .VALUE_BITS (VALUE_BITS)
  ) u_div (
    .clk        (clk),
    .ctl        (div_ctl),
    .base       (base),
    .load_value (is_neg ? value_neg : value_in),
    .stat       (div_stat)
  );

  itoab_digit_ram #(
    .DEPTH (VALUE_BITS)
  ) u_digits (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (div_stat.digit),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The digit count never runs past the size of the digit store.
  `ITOAB_ASSERT_ALWAYS(a_cnt_bound, digit_cnt <= CNT_W'(VALUE_BITS), "digit count overflow")

  // A minus sign is only emitted for base ten.
  `ITOAB_ASSERT_IMPL(a_sign_dec, state == ST_SIGN, base == RADIX_DEC && sign_pending, "sign outside base ten")

  // A minus sign is never the final character.
  `ITOAB_ASSERT_IMPL(a_sign_not_last, char_v && char_code == CHAR_MINUS, !char_last, "minus marked last")

  // Loading the final digit ends the item with a last beat on the output.
  `ITOAB_ASSERT_NEXT(a_last_ends, load_digit && digit_cnt == '0, state == ST_IDLE && char_v && char_last, "final digit did not end item")

endmodule

// ----- verif/integer_to_ascii_in_base_top_tb.sv -----
// Self-checking testbench for integer_to_ascii_in_base_top: numbers go in, ASCII text comes out.
// Depends on itoab_pkg, the itoab_num_if and itoab_char_if channels, and the block itself.
// A scoreboard class predicts every character and checks the output beats in order.
module integer_to_ascii_in_base_top_tb import itoab_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  // Predicts the text of every accepted number under the current radix and
  // checks each character beat against the oldest expected character.
  class radix_text_scoreboard;
    typedef struct packed {
      logic [CHAR_W-1:0] code;
      logic              last;
    } text_beat_t;

    logic [RADIX_W-1:0] radix;
    text_beat_t         expected_text[$];
    int unsigned        fault_count;

    function new();
      radix = RADIX_RESET;
      fault_count = 0;
    endfunction

    // Register values outside two to sixteen act as the nearest limit.
    function int unsigned effective_base();
      if (radix < RADIX_MIN) return RADIX_MIN;
      if (radix > RADIX_MAX) return RADIX_MAX;
      return radix;
    endfunction

    function void note_number(logic [NUMBER_W-1:0] number);
      logic [NUMBER_W-1:0] magnitude;
      logic [NUMBER_W-1:0] base;
      logic [DIGIT_W-1:0]  digits[$];
      text_beat_t          beat;
      base = effective_base();
      magnitude = number;
      // Only base ten shows a sign; every other base prints the raw pattern.
      if (base == RADIX_DEC && number[NUMBER_W-1]) begin
        magnitude = -number;
        beat.code = CHAR_MINUS;
        beat.last = 1'b0;
        expected_text.push_back(beat);
      end
      // Zero still produces one digit.
      do begin
        digits.push_front(DIGIT_W'(magnitude % base));
        magnitude = magnitude / base;
      end while (magnitude != 0);
      foreach (digits[i]) begin
        beat.code = (digits[i] < 10) ? CHAR_W'(8'h30 + digits[i]) : CHAR_W'(8'h37 + digits[i]);
        beat.last = (i == digits.size() - 1);
        expected_text.push_back(beat);
      end
    endfunction

    function void report(string what, logic [CHAR_W-1:0] want, logic [CHAR_W-1:0] got);
      fault_count++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
    endfunction

    function void check_char(logic [CHAR_W-1:0] code, logic last);
      text_beat_t want;
      if (expected_text.size() == 0) begin
        fault_count++;
        $display("%0t: character %h (last %b) arrived with no text pending, expected none",
                 $time, code, last);
        return;
      end
      want = expected_text.pop_front();
      if (code !== want.code) report("char_code", want.code, code);
      if (last !== want.last) report("last_char", CHAR_W'(want.last), CHAR_W'(last));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [RADIX_W-1:0] cfg_wdata;

  itoab_num_if  num_ch ();
  itoab_char_if text_ch ();

  integer_to_ascii_in_base_top dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .number_ch (num_ch),
    .char_ch   (text_ch)
  );

  radix_text_scoreboard text_board = new();

  // Beats left in the current sender burst; zero means a new burst starts,
  // possibly after a random gap.
  int unsigned burst_left = 0;

  logic [NUMBER_W-1:0] numbers[$];
  logic [RADIX_W-1:0]  radix_plan[$];

  // 8 ns clock, high and low for 4 ns each.
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Every character beat is checked at the rising edge where it is accepted.
  // Inputs only move at the falling edge, so the sampled values are stable.
  always @(posedge clk) begin
    if (!rst && text_ch.valid && text_ch.ready)
      text_board.check_char(text_ch.char_code, text_ch.last_char);
  end

  // The receiver runs its own stall pattern: stretches of steady readiness,
  // coin-flip stalls and heavy stalls, each of random length. This puts gaps
  // on the sign, the middle digits and the last digit alike.
  initial begin : receiver
    int unsigned mode;
    int unsigned span;
    text_ch.ready = 1'b0;
    forever begin
      mode = $urandom_range(0, 2);
      span = $urandom_range(8, 80);
      repeat (span) begin
        @(negedge clk);
        case (mode)
          0:       text_ch.ready <= 1'b1;
          1:       text_ch.ready <= 1'($urandom_range(0, 1));
          default: text_ch.ready <= ($urandom_range(0, 3) == 0);
        endcase
      end
    end
  end

  // Hard stop well beyond the slowest legal run (every number in base two
  // under heavy output stalls is under 5 ms).
  initial begin : watchdog
    #30_000_000;
    $display("integer_to_ascii_in_base_top test failed");
    $finish;
  end

  // Writes the radix register for one cycle and tells the scoreboard. Called
  // at a falling edge only while no text is outstanding.
  task automatic write_radix(input logic [RADIX_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(negedge clk);
    cfg_we    <= 1'b0;
    text_board.radix = value;
  endtask

  // Offers one number and returns at the falling edge after its acceptance.
  // Valid stays high across a burst, so back-to-back offers never drop it.
  task automatic offer_number(input logic [NUMBER_W-1:0] value);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 5);
      if (gap != 0) begin
        num_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      burst_left = $urandom_range(1, 6);
    end
    num_ch.valid  <= 1'b1;
    num_ch.number <= value;
    do @(posedge clk); while (!num_ch.ready);
    text_board.note_number(value);
    burst_left--;
    @(negedge clk);
  endtask

  // Sends a list of numbers, then waits until every character of their text
  // has been accepted, which leaves the block idle for a register write.
  task automatic play_numbers(input logic [NUMBER_W-1:0] values[$]);
    foreach (values[i])
      offer_number(values[i]);
    num_ch.valid <= 1'b0;
    burst_left = 0;
    while (text_board.expected_text.size() != 0)
      @(negedge clk);
  endtask

  // Random numbers leaning toward interesting text: full-width patterns,
  // short values around zero, the extremes, powers of the base and the values just
  // below them (where the digit count steps), and values of random width.
  function automatic logic [NUMBER_W-1:0] random_number();
    longint unsigned     power;
    longint unsigned     base;
    logic [NUMBER_W-1:0] pick;
    base = text_board.effective_base();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: pick = $urandom();
      4, 5:       pick = $urandom_range(0, 2000) - 1000;
      6: begin
        case ($urandom_range(0, 4))
          0:       pick = '0;
          1:       pick = 32'h0000_0001;
          2:       pick = '1;
          3:       pick = 32'h7FFF_FFFF;
          default: pick = 32'h8000_0000;
        endcase
      end
      7: begin
        power = 1;
        repeat ($urandom_range(1, 32))
          if (power * base <= 64'hFFFF_FFFF) power = power * base;
        pick = NUMBER_W'(power) - $urandom_range(0, 1);
        if ($urandom_range(0, 1)) pick = -pick;
      end
      default: begin
        pick = $urandom() >> $urandom_range(0, 31);
        if ($urandom_range(0, 1)) pick = -pick;
      end
    endcase
    return pick;
  endfunction

  initial begin : stimulus
    rst           = 1'b1;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    num_ch.valid  = 1'b0;
    num_ch.number = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part. The first list runs on the reset radix of ten: zero,
    // one, minus one, the largest value, the most negative value, and the
    // numbers around a change in digit count.
    numbers = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                32'h8000_0000, 32'h0000_000A, 32'hFFFF_FFF7};
    play_numbers(numbers);

    // Base sixteen uses every letter digit; negative patterns print unsigned.
    write_radix(RADIX_MAX);
    numbers = '{32'h0000_0000, 32'hFFFF_FFFF, 32'h8000_0000, 32'hFEDC_BA98,
                32'h0123_4567};
    play_numbers(numbers);

    // Base two gives the longest text, thirty-two characters.
    write_radix(RADIX_MIN);
    numbers = '{32'h0000_0000, 32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000};
    play_numbers(numbers);

    // Radix values below two act as two; the all-zero write also covers
    // every register bit low.
    write_radix(5'd0);
    numbers = '{32'h0000_0005, 32'hFFFF_FFFF};
    play_numbers(numbers);
    write_radix(5'd1);
    numbers = '{32'h0000_0006};
    play_numbers(numbers);

    // Radix values above sixteen act as sixteen; the all-ones write covers
    // every register bit high.
    write_radix(5'd17);
    numbers = '{32'hFFFF_FFFF, 32'h0000_00FF};
    play_numbers(numbers);
    write_radix(5'd31);
    numbers = '{32'hABCD_EF12};
    play_numbers(numbers);

    // An odd base with no sign: minus one prints as the unsigned maximum.
    write_radix(5'd3);
    numbers = '{32'hFFFF_FFFF};
    play_numbers(numbers);

    // Random part: twenty-six numbers per radix setting, the limits and the
    // out-of-range values among the settings, plus two random settings.
    radix_plan = '{RADIX_DEC, RADIX_MIN, RADIX_MAX, 5'd7, 5'd0, 5'd31, 5'd3, 5'd12,
                   5'd8, 5'd5, RADIX_DEC, 5'd17};
    radix_plan.push_back(RADIX_W'($urandom_range(0, 31)));
    radix_plan.push_back(RADIX_W'($urandom_range(2, 16)));
    foreach (radix_plan[p]) begin
      write_radix(radix_plan[p]);
      numbers.delete();
      repeat (26) numbers.push_back(random_number());
      play_numbers(numbers);
    end

    // Everything expected has arrived; give a stray beat time to show up.
    repeat (100) @(posedge clk);
    if (text_board.fault_count == 0)
      $display("integer_to_ascii_in_base_top test passed");
    else
      $display("integer_to_ascii_in_base_top test failed");
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+src
src/itoab_pkg.sv
src/itoab_if.sv
src/itoab_serial_div.sv
src/itoab_digit_ram.sv
src/integer_to_ascii_in_base_top.sv
verif/integer_to_ascii_in_base_top_tb.sv
